// File: design/mutwa_pkg.sv
// Shared types, constants and codes for the MAC user table with aging.
// Used by every module of the block but mutwa_ram; depends on nothing.
package mutwa_pkg;

  localparam int ENTRIES = 1024;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = IDX_W + 1;

  localparam logic [29:0] SWEEP_INTERVAL_RESET = 30'd300000;

  localparam logic [3:0] FUNC_ADD        = 4'd0;
  localparam logic [3:0] FUNC_LOOKUP     = 4'd1;
  localparam logic [3:0] FUNC_SET_STATUS = 4'd2;
  localparam logic [3:0] FUNC_SET_AUTH   = 4'd3;
  localparam logic [3:0] FUNC_SET_ADDR   = 4'd4;
  localparam logic [3:0] FUNC_TOUCH      = 4'd5;
  localparam logic [3:0] FUNC_KICK       = 4'd6;
  localparam logic [3:0] FUNC_TICK       = 4'd7;
  localparam logic [3:0] FUNC_CLEAR      = 4'd8;

  localparam logic [1:0] AUTH_UNKNOWN = 2'd0;
  localparam logic [1:0] AUTH_AUTO    = 2'd1;

  typedef enum logic [3:0] {
    OP_ADD,
    OP_LOOKUP,
    OP_SET_STATUS,
    OP_SET_AUTH,
    OP_SET_ADDR,
    OP_TOUCH,
    OP_KICK,
    OP_TICK,
    OP_CLEAR,
    OP_NONE
  } op_t;

  typedef struct packed {
    logic [3:0]  func;
    logic [47:0] mac;
    logic [31:0] ipv4;
    logic        status;
    logic [1:0]  auth_mode;
  } item_t;

  typedef struct packed {
    logic        found;
    logic        error;
    logic [31:0] user_ipv4;
    logic        user_online;
    logic [1:0]  user_auth_type;
    logic [10:0] removed_count;
  } result_t;

  typedef struct packed {
    op_t         op;
    logic [47:0] mac;
    logic [31:0] ipv4;
    logic        status;
    logic [1:0]  auth_mode;
  } job_t;

  typedef struct packed {
    logic        valid;
    logic [47:0] mac;
    logic [31:0] addr;
    logic        online;
    logic [1:0]  kind;
    logic [31:0] last;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: design/mutwa_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; no package needed.
module mutwa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/mutwa_front.sv
// Front end: decodes each request into an operation and holds it in a two-deep queue.
// Depends on mutwa_pkg.
module mutwa_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                clearing,
  input  logic                item_valid,
  output logic                item_ready,
  input  mutwa_pkg::item_t    item,
  output logic                q_valid,
  input  logic                q_pop,
  output mutwa_pkg::job_t     q_job
);

  mutwa_pkg::job_t slot [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  mutwa_pkg::job_t job;
  logic            push;
  logic            pop;

  always_comb begin
    job.mac       = item.mac;
    job.ipv4      = item.ipv4;
    job.status    = item.status;
    job.auth_mode = item.auth_mode;
    unique case (item.func)
      mutwa_pkg::FUNC_ADD:        job.op = mutwa_pkg::OP_ADD;
      mutwa_pkg::FUNC_LOOKUP:     job.op = mutwa_pkg::OP_LOOKUP;
      mutwa_pkg::FUNC_SET_STATUS: job.op = mutwa_pkg::OP_SET_STATUS;
      mutwa_pkg::FUNC_SET_AUTH:   job.op = mutwa_pkg::OP_SET_AUTH;
      mutwa_pkg::FUNC_SET_ADDR:   job.op = mutwa_pkg::OP_SET_ADDR;
      mutwa_pkg::FUNC_TOUCH:      job.op = mutwa_pkg::OP_TOUCH;
      mutwa_pkg::FUNC_KICK:       job.op = mutwa_pkg::OP_KICK;
      mutwa_pkg::FUNC_TICK:       job.op = mutwa_pkg::OP_TICK;
      mutwa_pkg::FUNC_CLEAR:      job.op = mutwa_pkg::OP_CLEAR;
      default:                    job.op = mutwa_pkg::OP_NONE;
    endcase
  end

  // No request is taken while the table is being cleared after reset.
  assign item_ready = (count != 2'd2) && !clearing;
  assign push       = item_valid && item_ready;
  assign q_valid    = (count != 2'd0);
  assign pop        = q_pop && q_valid;
  assign q_job      = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= job;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: design/mutwa_back.sv
// Back end: walks the entry table for each queued operation, runs aging sweeps,
// keeps time and the sweep interval, and holds the result register.
// Depends on mutwa_pkg and mutwa_ram.
module mutwa_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [29:0]         cfg_data,
  input  logic                q_valid,
  output logic                q_pop,
  input  mutwa_pkg::job_t     q_job,
  output logic                clearing,
  output logic                result_valid,
  input  logic                result_ready,
  output mutwa_pkg::result_t  result
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WALK   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t                          state;
  logic                            init;
  mutwa_pkg::job_t                 cur;
  logic [mutwa_pkg::CNT_W-1:0]     rd_cnt;
  logic                            pend;
  logic [mutwa_pkg::IDX_W-1:0]     pend_idx;
  logic                            hit;
  logic [mutwa_pkg::IDX_W-1:0]     hit_idx;
  mutwa_pkg::entry_t               hit_ent;
  logic                            free_seen;
  logic [mutwa_pkg::IDX_W-1:0]     free_idx;
  logic [mutwa_pkg::CNT_W-1:0]     removed;
  logic [31:0]                     now;
  logic [29:0]                     countdown;
  logic [29:0]                     interval;

  logic                            we;
  logic [mutwa_pkg::IDX_W-1:0]     waddr;
  mutwa_pkg::entry_t               wdata;
  logic [mutwa_pkg::ENTRY_W-1:0]   rdata_raw;
  mutwa_pkg::entry_t               rdata;

  logic [31:0]                     off_lim;
  logic [31:0]                     del_lim;
  logic [31:0]                     idle;
  logic                            sweep_del;
  logic                            is_mac_op;
  logic                            fin_go;
  logic [29:0]                     countdown_next;
  mutwa_pkg::entry_t               upd;
  mutwa_pkg::entry_t               fresh;
  mutwa_pkg::result_t              res;

  mutwa_ram #(
    .WIDTH (mutwa_pkg::ENTRY_W),
    .DEPTH (mutwa_pkg::ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_cnt[mutwa_pkg::IDX_W-1:0]),
    .rdata (rdata_raw)
  );

  assign rdata     = rdata_raw;
  assign cfg_ready = 1'b1;
  assign clearing  = init;
  assign q_pop     = (state == S_IDLE) && q_valid;

  assign off_lim   = {1'b0, interval, 1'b0};
  assign del_lim   = {interval, 2'b00};
  assign idle      = now - rdata.last;
  assign sweep_del = rdata.valid && (idle >= del_lim);
  assign is_mac_op = (cur.op == mutwa_pkg::OP_ADD) || (cur.op == mutwa_pkg::OP_LOOKUP) ||
                     (cur.op == mutwa_pkg::OP_SET_STATUS) ||
                     (cur.op == mutwa_pkg::OP_SET_AUTH) ||
                     (cur.op == mutwa_pkg::OP_SET_ADDR) || (cur.op == mutwa_pkg::OP_TOUCH);
  assign fin_go    = (state == S_FINISH) && (init || !result_valid || result_ready);
  assign countdown_next = countdown + 30'd1;

  always_comb begin
    fresh        = '0;
    fresh.valid  = 1'b1;
    fresh.mac    = cur.mac;
    fresh.addr   = cur.ipv4;
    fresh.online = 1'b0;
    fresh.kind   = mutwa_pkg::AUTH_UNKNOWN;
    fresh.last   = now;

    upd = hit_ent;
    case (cur.op)
      mutwa_pkg::OP_SET_STATUS: upd.online = cur.status;
      mutwa_pkg::OP_SET_AUTH:   upd.kind   = cur.auth_mode;
      mutwa_pkg::OP_SET_ADDR:   upd.addr   = cur.ipv4;
      mutwa_pkg::OP_TOUCH:      upd.last   = now;
      default:                  upd        = hit_ent;
    endcase

    res               = '0;
    res.removed_count = 11'(removed);
    if (is_mac_op) begin
      res.found = hit;
      if (hit) begin
        res.user_ipv4      = upd.addr;
        res.user_online    = upd.online;
        res.user_auth_type = upd.kind;
      end else if (cur.op == mutwa_pkg::OP_ADD) begin
        if (free_seen) begin
          res.user_ipv4      = fresh.addr;
          res.user_online    = fresh.online;
          res.user_auth_type = fresh.kind;
        end else begin
          res.error = 1'b1;
        end
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = pend_idx;
    wdata = rdata;
    if ((state == S_WALK) && pend) begin
      case (cur.op)
        mutwa_pkg::OP_CLEAR: begin
          we          = 1'b1;
          wdata.valid = 1'b0;
        end
        mutwa_pkg::OP_KICK: begin
          if (rdata.valid && (rdata.kind == mutwa_pkg::AUTH_AUTO)) begin
            we           = 1'b1;
            wdata.online = 1'b0;
          end
        end
        mutwa_pkg::OP_TICK: begin
          if (sweep_del) begin
            we          = 1'b1;
            wdata.valid = 1'b0;
          end else if (rdata.valid && (idle >= off_lim)) begin
            we           = 1'b1;
            wdata.online = 1'b0;
          end
        end
        default: we = 1'b0;
      endcase
    end else if (fin_go && !init && is_mac_op) begin
      if (hit) begin
        we    = (cur.op != mutwa_pkg::OP_ADD) && (cur.op != mutwa_pkg::OP_LOOKUP);
        waddr = hit_idx;
        wdata = upd;
      end else if ((cur.op == mutwa_pkg::OP_ADD) && free_seen) begin
        we    = 1'b1;
        waddr = free_idx;
        wdata = fresh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_WALK;
      init         <= 1'b1;
      cur.op       <= mutwa_pkg::OP_CLEAR;
      rd_cnt       <= '0;
      pend         <= 1'b0;
      hit          <= 1'b0;
      free_seen    <= 1'b0;
      removed      <= '0;
      result_valid <= 1'b0;
      now          <= '0;
      countdown    <= '0;
      interval     <= mutwa_pkg::SWEEP_INTERVAL_RESET;
    end else begin
      if (cfg_valid) begin
        interval <= cfg_data;
      end
      if (result_valid && result_ready && !(fin_go && !init)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur       <= q_job;
            rd_cnt    <= '0;
            pend      <= 1'b0;
            hit       <= 1'b0;
            free_seen <= 1'b0;
            removed   <= '0;
            case (q_job.op)
              mutwa_pkg::OP_TICK: begin
                now <= now + 32'd1;
                if (countdown_next >= interval) begin
                  countdown <= '0;
                  state     <= S_WALK;
                end else begin
                  countdown <= countdown_next;
                  state     <= S_FINISH;
                end
              end
              mutwa_pkg::OP_NONE: state <= S_FINISH;
              default:            state <= S_WALK;
            endcase
          end
        end
        S_WALK: begin
          if (rd_cnt < mutwa_pkg::CNT_W'(mutwa_pkg::ENTRIES)) begin
            rd_cnt <= rd_cnt + mutwa_pkg::CNT_W'(1);
          end
          pend     <= (rd_cnt < mutwa_pkg::CNT_W'(mutwa_pkg::ENTRIES));
          pend_idx <= rd_cnt[mutwa_pkg::IDX_W-1:0];
          if (pend) begin
            if (is_mac_op && rdata.valid && (rdata.mac == cur.mac) && !hit) begin
              hit     <= 1'b1;
              hit_idx <= pend_idx;
              hit_ent <= rdata;
            end
            if (is_mac_op && !rdata.valid && !free_seen) begin
              free_seen <= 1'b1;
              free_idx  <= pend_idx;
            end
            if ((cur.op == mutwa_pkg::OP_TICK) && sweep_del) begin
              removed <= removed + mutwa_pkg::CNT_W'(1);
            end
          end
          if ((rd_cnt == mutwa_pkg::CNT_W'(mutwa_pkg::ENTRIES)) && !pend) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (fin_go) begin
            if (!init) begin
              result       <= res;
              result_valid <= 1'b1;
            end
            init  <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/mac_user_table_with_aging.sv
// Top level of the MAC user table with aging: joins the front end and the back end.
// Depends on mutwa_pkg, mutwa_front and mutwa_back.
//
//   channel  handshake                  payload
//   -------  -------------------------  -------------------------------
//   item     item_valid / item_ready    item   (mutwa_pkg::item_t)
//   result   result_valid / result_ready result (mutwa_pkg::result_t)
//   cfg      cfg_valid / cfg_ready      cfg_data (sweep interval, 30 bits)
//
// A request that looks up a MAC, a kick, a clear and a tick that sweeps each walk
// the whole table through one RAM read port. A tick without a sweep and an unused
// code skip the walk. After reset a clearing pass runs before any request is taken;
// cfg writes are always taken.
// Two requests queue ahead of the table walker; a stalled result holds the walker.
module mac_user_table_with_aging (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  mutwa_pkg::item_t    item,
  output logic                result_valid,
  input  logic                result_ready,
  output mutwa_pkg::result_t  result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [29:0]         cfg_data
);

  logic            q_valid;
  logic            q_pop;
  mutwa_pkg::job_t q_job;
  logic            clearing;

  mutwa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .clearing   (clearing),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_job      (q_job)
  );

  mutwa_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_job        (q_job),
    .clearing     (clearing),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// File: design/mutwa_checker.sv
// Port-level checks for the MAC user table with aging, bound to the top level.
// Depends on mutwa_pkg and mac_user_table_with_aging.
module mutwa_checker (
  input logic               clk,
  input logic               rst,
  input logic               result_valid,
  input logic               result_ready,
  input mutwa_pkg::result_t result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

  a_error_not_found: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.error |-> !result.found && (result.user_ipv4 == 32'd0) &&
      !result.user_online && (result.user_auth_type == 2'd0))
    else $error("table-full result carries user data");

  a_sweep_no_user: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.removed_count != 11'd0) |->
      !result.found && !result.error && (result.user_ipv4 == 32'd0))
    else $error("sweep result carries user data");

  a_removed_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.removed_count <= 11'(mutwa_pkg::ENTRIES))
    else $error("removed count exceeds table size");

endmodule

bind mac_user_table_with_aging mutwa_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// File: test/tb_mac_user_table_with_aging.sv
// Testbench for the MAC user table with aging: directed and random requests with
// an in-bench model of the table, aging sweeps and sweep interval register.
// Depends on mutwa_pkg and mac_user_table_with_aging.
`timescale 1ns / 1ps

module tb_mac_user_table_with_aging;

  localparam int N = mutwa_pkg::ENTRIES;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  mutwa_pkg::item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  mutwa_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [29:0] cfg_data = '0;

  mac_user_table_with_aging u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model of the user table.
  logic        tbl_valid [N];
  logic [47:0] tbl_mac   [N];
  logic [31:0] tbl_addr  [N];
  logic        tbl_online[N];
  logic [1:0]  tbl_kind  [N];
  logic [31:0] tbl_last  [N];
  logic [31:0] now_ticks = '0;
  logic [29:0] countdown = '0;
  logic [29:0] interval = mutwa_pkg::SWEEP_INTERVAL_RESET;

  mutwa_pkg::item_t   pending_items[$];
  mutwa_pkg::result_t expected_results[$];
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_swept = 0;
  int n_full = 0;
  bit long_hold_req = 0;
  bit long_hold_done = 0;
  int hold_left = 0;
  logic [47:0] mac_pool[24];

  initial for (int i = 0; i < N; i++) tbl_valid[i] = 1'b0;

  function automatic mutwa_pkg::result_t table_apply(mutwa_pkg::item_t it);
    mutwa_pkg::result_t r;
    int idx;
    int i;
    logic [31:0] idle;
    logic [31:0] off_lim;
    logic [31:0] del_lim;
    logic [10:0] removed;
    r = '0;
    idx = -1;
    removed = '0;
    if (it.func <= mutwa_pkg::FUNC_TOUCH) begin
      for (i = 0; i < N; i++)
        if (idx < 0 && tbl_valid[i] && tbl_mac[i] == it.mac) idx = i;
      r.found = (idx >= 0);
    end
    case (it.func)
      mutwa_pkg::FUNC_ADD: begin
        if (idx < 0) begin
          for (i = 0; i < N; i++)
            if (idx < 0 && !tbl_valid[i]) idx = i;
          if (idx >= 0) begin
            tbl_valid[idx] = 1'b1;
            tbl_mac[idx] = it.mac;
            tbl_addr[idx] = it.ipv4;
            tbl_online[idx] = 1'b0;
            tbl_kind[idx] = mutwa_pkg::AUTH_UNKNOWN;
            tbl_last[idx] = now_ticks;
          end else begin
            r.error = 1'b1;
            n_full++;
          end
        end
      end
      mutwa_pkg::FUNC_SET_STATUS: if (idx >= 0) tbl_online[idx] = it.status;
      mutwa_pkg::FUNC_SET_AUTH:   if (idx >= 0) tbl_kind[idx] = it.auth_mode;
      mutwa_pkg::FUNC_SET_ADDR:   if (idx >= 0) tbl_addr[idx] = it.ipv4;
      mutwa_pkg::FUNC_TOUCH:      if (idx >= 0) tbl_last[idx] = now_ticks;
      mutwa_pkg::FUNC_KICK: begin
        for (i = 0; i < N; i++)
          if (tbl_valid[i] && tbl_kind[i] == mutwa_pkg::AUTH_AUTO) tbl_online[i] = 1'b0;
      end
      mutwa_pkg::FUNC_TICK: begin
        now_ticks = now_ticks + 32'd1;
        countdown = countdown + 30'd1;
        if (countdown >= interval) begin
          countdown = '0;
          off_lim = {1'b0, interval, 1'b0};
          del_lim = {interval, 2'b00};
          for (i = 0; i < N; i++) begin
            if (tbl_valid[i]) begin
              idle = now_ticks - tbl_last[i];
              if (idle >= del_lim) begin
                tbl_valid[i] = 1'b0;
                removed++;
              end else if (idle >= off_lim) begin
                tbl_online[i] = 1'b0;
              end
            end
          end
          if (removed != 0) n_swept++;
        end
      end
      mutwa_pkg::FUNC_CLEAR: for (i = 0; i < N; i++) tbl_valid[i] = 1'b0;
      default: ;
    endcase
    if (idx >= 0) begin
      r.user_ipv4 = tbl_addr[idx];
      r.user_online = tbl_online[idx];
      r.user_auth_type = tbl_kind[idx];
    end
    r.removed_count = removed;
    return r;
  endfunction

  // Driver: offers queued requests and predicts each one as it is taken.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_ready) begin
      if (item_valid) begin
        expected_results.push_back(table_apply(item));
        n_items++;
      end
      if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        item_valid <= 1'b1;
        item <= pending_items.pop_front();
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Receiver with random stalls and one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_ready <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold_left <= 6000;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result);
        errors++;
      end else begin
        mutwa_pkg::result_t e;
        e = expected_results.pop_front();
        if (e.found !== result.found || e.error !== result.error ||
            e.user_ipv4 !== result.user_ipv4 || e.user_online !== result.user_online ||
            e.user_auth_type !== result.user_auth_type ||
            e.removed_count !== result.removed_count) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, result);
          errors++;
        end
      end
    end
  end

  task automatic wait_idle();
    while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (N + 8) @(posedge clk);
  endtask

  task automatic write_interval(logic [29:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    interval = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic push(logic [3:0] f, logic [47:0] m, logic [31:0] a, logic s,
                      logic [1:0] k);
    mutwa_pkg::item_t it;
    it.func = f;
    it.mac = m;
    it.ipv4 = a;
    it.status = s;
    it.auth_mode = k;
    pending_items.push_back(it);
  endtask

  task automatic push_random(int count);
    logic [3:0] f;
    logic [47:0] m;
    int w;
    repeat (count) begin
      w = $urandom_range(99);
      if (w < 22) f = mutwa_pkg::FUNC_ADD;
      else if (w < 32) f = mutwa_pkg::FUNC_LOOKUP;
      else if (w < 42) f = mutwa_pkg::FUNC_SET_STATUS;
      else if (w < 52) f = mutwa_pkg::FUNC_SET_AUTH;
      else if (w < 58) f = mutwa_pkg::FUNC_SET_ADDR;
      else if (w < 68) f = mutwa_pkg::FUNC_TOUCH;
      else if (w < 72) f = mutwa_pkg::FUNC_KICK;
      else if (w < 96) f = mutwa_pkg::FUNC_TICK;
      else if (w < 97) f = mutwa_pkg::FUNC_CLEAR;
      else f = 4'($urandom_range(15));
      m = ($urandom_range(9) < 8) ? mac_pool[$urandom_range(23)]
                                  : {16'($urandom), 32'($urandom)};
      push(f, m, $urandom, 1'($urandom), 2'($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < 24; i++) mac_pool[i] = {16'($urandom), 32'($urandom)};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every function, absent users and unused codes.
    push(mutwa_pkg::FUNC_ADD, 48'h0, 32'h0, 1'b0, 2'd0);
    push(mutwa_pkg::FUNC_ADD, '1, '1, 1'b1, 2'd3);
    push(mutwa_pkg::FUNC_ADD, '1, 32'h1234_5678, 1'b0, 2'd0);
    push(mutwa_pkg::FUNC_LOOKUP, '1, '0, 1'b0, 2'd0);
    push(mutwa_pkg::FUNC_LOOKUP, 48'h5, '0, 1'b0, 2'd0);
    push(mutwa_pkg::FUNC_SET_STATUS, '1, '0, 1'b1, 2'd0);
    push(mutwa_pkg::FUNC_SET_AUTH, '1, '0, 1'b0, 2'd3);
    push(mutwa_pkg::FUNC_SET_AUTH, 48'h0, '0, 1'b0, mutwa_pkg::AUTH_AUTO);
    push(mutwa_pkg::FUNC_SET_STATUS, 48'h0, '0, 1'b1, 2'd0);
    push(mutwa_pkg::FUNC_SET_ADDR, 48'h0, 32'hFFFF_0000, 1'b0, 2'd0);
    push(mutwa_pkg::FUNC_TOUCH, 48'h0, '0, 1'b0, 2'd0);
    push(mutwa_pkg::FUNC_SET_STATUS, 48'h7, '0, 1'b1, 2'd2);
    push(mutwa_pkg::FUNC_SET_AUTH, 48'h7, '0, 1'b1, 2'd2);
    push(mutwa_pkg::FUNC_SET_ADDR, 48'h7, '1, 1'b1, 2'd2);
    push(mutwa_pkg::FUNC_TOUCH, 48'h7, '0, 1'b0, 2'd0);
    push(mutwa_pkg::FUNC_KICK, '0, '0, 1'b0, 2'd0);
    push(mutwa_pkg::FUNC_LOOKUP, 48'h0, '0, 1'b0, 2'd0);
    push(4'd9, '1, '1, 1'b1, 2'd3);
    push(4'd15, '1, '1, 1'b1, 2'd3);
    push(mutwa_pkg::FUNC_TICK, '0, '0, 1'b0, 2'd0);
    push(mutwa_pkg::FUNC_CLEAR, '0, '0, 1'b0, 2'd0);
    push(mutwa_pkg::FUNC_LOOKUP, '1, '0, 1'b0, 2'd0);

    // A zero interval sweeps on every tick and removes everything.
    write_interval(30'd0);
    push(mutwa_pkg::FUNC_ADD, mac_pool[0], 32'h0A00_0001, 1'b0, 2'd0);
    push(mutwa_pkg::FUNC_ADD, mac_pool[1], 32'h0A00_0002, 1'b0, 2'd0);
    push(mutwa_pkg::FUNC_TICK, '0, '0, 1'b0, 2'd0);
    push(mutwa_pkg::FUNC_LOOKUP, mac_pool[0], '0, 1'b0, 2'd0);

    // Random phases with different sweep intervals and idling patterns.
    write_interval(30'd3);
    push_random(138);
    write_interval(30'd1);
    sender_idle_pct = 62;
    push_random(138);
    write_interval('1);
    sender_idle_pct = 0;
    stall_pct = 62;
    push_random(138);
    write_interval(30'd5);
    sender_idle_pct = 28;
    stall_pct = 28;
    long_hold_req = 1;
    push_random(138);

    write_interval(mutwa_pkg::SWEEP_INTERVAL_RESET);

    wait_idle();
    $display("Covered %0d requests and %0d results over six sweep intervals,", n_items,
             n_results);
    $display("%0d sweeps that removed users and %0d adds to a full table.", n_swept, n_full);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
